[rtl/core/dq_pkg.sv]
// Shared types and constants for the double-ended queue.
// Holds opcode and status codes and the cell mode type; no dependencies.
package dq_pkg;

  localparam int OP_W     = 3;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_LIST       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_LOAD
  } cell_mode_t;

endpackage

[rtl/core/dq_cell.sv]
// One storage cell of the deque ring: holds a word, or takes it from a
// neighbor or from the input. Depends on dq_pkg.
module dq_cell import dq_pkg::*; #(
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  cell_mode_t        mode,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  input  logic [DATA_W-1:0] load_data,
  output logic [DATA_W-1:0] data
);

  always_ff @(posedge clk) begin
    unique case (mode)
      CELL_HOLD:       data <= data;
      CELL_FROM_LEFT:  data <= left_data;
      CELL_FROM_RIGHT: data <= right_data;
      CELL_LOAD:       data <= load_data;
    endcase
  end

endmodule

[rtl/core/dq_outq.sv]
// Two-entry result queue between the deque core and the output channel.
// Lets a new word enter while an earlier one waits; no dependencies.
module dq_outq #(
  parameter int W = 35
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] entry [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   fill;
  logic         pop;

  assign pop       = pop_valid && pop_ready;
  assign full      = (fill == 2'd2);
  assign pop_valid = (fill != 2'd0);
  assign pop_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

[rtl/core/double_ended_queue_top.sv]
// Double-ended queue: a ring of DEPTH cells, front at cell 0 while idle. Push
// and pop update the ring and queue their status word at acceptance. A list
// rotates the ring until the element at position is at cell 0, emits one
// element per cycle while the output queue has room, then rotates back by the
// shortest way; input is held off for all of it. Reset clears fill count,
// rotation, sequencer and output queue; cell contents stay undefined.
module double_ended_queue_top import dq_pkg::*; #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     opcode,
  input  logic [DATA_W-1:0]   record,
  input  logic [POS_W-1:0]    position,
  input  logic                direction,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [DATA_W-1:0]   element,
  output logic                last
);

  localparam int RW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int OW   = STATUS_W + DATA_W + 1;
  localparam logic [RW-1:0] ROT_MAX  = RW'(DEPTH - 1);
  localparam logic [RW-1:0] ROT_HALF = RW'((DEPTH + 1) / 2);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SKIP,
    S_EMIT,
    S_RESTORE
  } state_t;

  state_t              state, state_next;
  logic [CW-1:0]       count, count_next;
  logic [RW-1:0]       rot, rot_next;
  logic [CW-1:0]       skip, skip_next;
  logic [CW-1:0]       remain, remain_next;
  logic                dir, dir_next;

  logic                accept;
  logic [RW-1:0]       rot_inc;
  logic [RW-1:0]       rot_dec;
  cell_mode_t          ring_mode;
  logic                front_load;
  logic                back_load;
  logic                q_push;
  logic                q_full;
  logic [STATUS_W-1:0] q_status;
  logic [DATA_W-1:0]   q_elem;
  logic                q_last;
  logic [OW-1:0]       q_out;
  logic                pos_bad;

  cell_mode_t          cell_mode [DEPTH];
  logic [DATA_W-1:0]   cell_data [DEPTH];

  assign in_ready = (state == S_IDLE) && !q_full;
  assign accept   = in_valid && in_ready;
  assign rot_inc  = (rot == ROT_MAX) ? '0 : rot + RW'(1);
  assign rot_dec  = (rot == '0) ? ROT_MAX : rot - RW'(1);
  assign pos_bad  = (position == '0) || (CMPW'(position) > CMPW'(count));

  always_comb begin
    state_next  = state;
    count_next  = count;
    rot_next    = rot;
    skip_next   = skip;
    remain_next = remain;
    dir_next    = dir;
    ring_mode   = CELL_HOLD;
    front_load  = 1'b0;
    back_load   = 1'b0;
    q_push      = 1'b0;
    q_status    = ST_OK;
    q_elem      = '0;
    q_last      = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (opcode)
            OP_PUSH_FRONT: begin
              q_push = 1'b1;
              if (count == CNT_FULL) begin
                q_status = ST_FULL;
              end else begin
                ring_mode  = CELL_FROM_LEFT;
                front_load = 1'b1;
                count_next = count + CW'(1);
              end
            end
            OP_PUSH_BACK: begin
              q_push = 1'b1;
              if (count == CNT_FULL) begin
                q_status = ST_FULL;
              end else begin
                back_load  = 1'b1;
                count_next = count + CW'(1);
              end
            end
            OP_POP_FRONT: begin
              q_push = 1'b1;
              if (count == '0) begin
                q_status = ST_EMPTY;
              end else begin
                ring_mode  = CELL_FROM_RIGHT;
                count_next = count - CW'(1);
              end
            end
            OP_POP_BACK: begin
              q_push = 1'b1;
              if (count == '0) begin
                q_status = ST_EMPTY;
              end else begin
                count_next = count - CW'(1);
              end
            end
            OP_LIST: begin
              if (count == '0) begin
                q_push   = 1'b1;
                q_status = ST_EMPTY;
              end else if (pos_bad) begin
                q_push   = 1'b1;
                q_status = ST_RANGE;
              end else begin
                skip_next = CW'(CMPW'(position) - CMPW'(1));
                dir_next  = direction;
                if (direction) begin
                  remain_next = CW'(CMPW'(position));
                end else begin
                  remain_next = CW'(CMPW'(count) - CMPW'(position) + CMPW'(1));
                end
                state_next = (position == POS_W'(1)) ? S_EMIT : S_SKIP;
              end
            end
            default: ;
          endcase
        end
      end
      S_SKIP: begin
        ring_mode = CELL_FROM_RIGHT;
        rot_next  = rot_inc;
        skip_next = skip - CW'(1);
        if (skip == CW'(1)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!q_full) begin
          q_push      = 1'b1;
          q_elem      = cell_data[0];
          q_last      = (remain == CW'(1));
          ring_mode   = dir ? CELL_FROM_LEFT : CELL_FROM_RIGHT;
          rot_next    = dir ? rot_dec : rot_inc;
          remain_next = remain - CW'(1);
          if (remain == CW'(1)) begin
            state_next = (rot_next == '0) ? S_IDLE : S_RESTORE;
          end
        end
      end
      S_RESTORE: begin
        if (rot >= ROT_HALF) begin
          ring_mode = CELL_FROM_RIGHT;
          rot_next  = rot_inc;
        end else begin
          ring_mode = CELL_FROM_LEFT;
          rot_next  = rot_dec;
        end
        if (rot_next == '0) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      rot    <= '0;
      skip   <= '0;
      remain <= '0;
      dir    <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      rot    <= rot_next;
      skip   <= skip_next;
      remain <= remain_next;
      dir    <= dir_next;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cell_mode[i] = ((front_load && (i == 0)) ||
                           (back_load && (count == CW'(i)))) ? CELL_LOAD : ring_mode;

    dq_cell #(
      .DATA_W(DATA_W)
    ) u_cell (
      .clk       (clk),
      .mode      (cell_mode[i]),
      .left_data (cell_data[(i + DEPTH - 1) % DEPTH]),
      .right_data(cell_data[(i + 1) % DEPTH]),
      .load_data (record),
      .data      (cell_data[i])
    );
  end

  dq_outq #(
    .W(OW)
  ) u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data({q_status, q_elem, q_last}),
    .full     (q_full),
    .pop_valid(out_valid),
    .pop_ready(out_ready),
    .pop_data (q_out)
  );

  assign status  = q_out[OW-1 -: STATUS_W];
  assign element = q_out[DATA_W:1];
  assign last    = q_out[0];

endmodule
